[design/packet_body_framer_crc16_unit_defines.svh]
// assertion macros for the packet body framer
// used by packet_body_framer_crc16_unit; expects clk and rst in scope
`ifndef PACKET_BODY_FRAMER_CRC16_UNIT_DEFINES_SVH
`define PACKET_BODY_FRAMER_CRC16_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PBF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pbf: assertion failed");
`define PBF_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("pbf: forbidden condition seen");
`else
`define PBF_ASSERT(lbl, prop)
`define PBF_NEVER(lbl, expr)
`endif
`endif

[design/pbf_pkg.sv]
// shared types, codes and crc helper for the packet body framer
// no dependencies
`default_nettype none

package pbf_pkg;

  localparam int MAX_RESULTS = 6;
  localparam int CNT_W       = 3;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_DATA   = 1'b1;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_LEN    = 2'd1;
  localparam logic [1:0] STAT_NO_PKT = 2'd2;

  typedef struct packed {
    logic        command;
    logic [7:0]  flags;
    logic [7:0]  seq;
    logic [15:0] length;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic [15:0] crc;
    logic [15:0] remaining;
    logic        pkt_open;
  } frame_state_t;

  typedef result_t [MAX_RESULTS-1:0] result_list_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[design/packet_body_framer_crc16_unit.sv]
// channel      dir  payload   handshake
// item         in   item_t    item_valid / item_ready
// result       out  result_t  result_valid / result_ready
//
// a beat accepted on item is framed combinationally and stored into a buffer of up to six result beats
// the buffer drains one result per cycle while result_ready is high; a header gives 1, 4 or 6, a payload byte 1 or 3
// item_ready is high when the buffer is empty or its last beat leaves this cycle
// so payload bytes that close no packet flow at one per cycle while result_ready is high
// rst is synchronous; it clears the crc to 0xffff, closes any packet, drops the buffer
//
// depends on pbf_pkg, pbf_frame and packet_body_framer_crc16_unit_defines.svh
`include "packet_body_framer_crc16_unit_defines.svh"
`default_nettype none

module packet_body_framer_crc16_unit import pbf_pkg::*; #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  frame_state_t     st, st_next;
  result_list_t     res;
  logic [CNT_W-1:0] res_cnt;
  logic [CNT_W-1:0] rem, idx;
  result_t          slots [MAX_RESULTS];
  logic             take_in, take_out;

  pbf_frame #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_frame (
    .item    (item),
    .st      (st),
    .st_next (st_next),
    .res     (res),
    .res_cnt (res_cnt)
  );

  assign result_valid = (rem != '0);
  assign result       = slots[idx];
  assign item_ready   = (rem == '0) || ((rem == CNT_W'(1)) && result_ready);
  assign take_in      = item_valid && item_ready;
  assign take_out     = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= '{crc: CRC_INIT, remaining: 16'd0, pkt_open: 1'b0};
      rem <= '0;
      idx <= '0;
    end else if (take_in) begin
      st  <= st_next;
      rem <= res_cnt;
      idx <= '0;
    end else if (take_out) begin
      rem <= rem - CNT_W'(1);
      idx <= idx + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        slots[i] <= res[i];
      end
    end
  end

  `PBF_ASSERT(a_accept_fills, take_in |=> result_valid)
  `PBF_NEVER(a_buf_bound, (32'(rem) + 32'(idx)) > MAX_RESULTS)
  `PBF_NEVER(a_open_has_count, st.pkt_open && (st.remaining == 16'd0))
  `PBF_ASSERT(a_last_ends_buf, (take_out && result.last && !take_in) |=> !result_valid)

endmodule

`default_nettype wire

[design/pbf_frame.sv]
// framing decision for one beat: result bytes and next state
// depends on pbf_pkg
`default_nettype none

module pbf_frame import pbf_pkg::*; #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  item_t              item,
  input  frame_state_t       st,
  output frame_state_t       st_next,
  output result_list_t       res,
  output logic [CNT_W-1:0]   res_cnt
);

  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  logic [15:0] c1, c2, c3, c4, cd;
  logic [15:0] rem_dec;

  always_comb begin
    c1      = crc_feed(CRC_INIT, item.flags);
    c2      = crc_feed(c1, item.seq);
    c3      = crc_feed(c2, item.length[15:8]);
    c4      = crc_feed(c3, item.length[7:0]);
    cd      = crc_feed(st.crc, item.data_byte);
    rem_dec = st.remaining - 16'd1;

    res     = '0;
    res_cnt = CNT_W'(1);
    st_next = st;

    if (item.command == CMD_HEADER) begin
      if (item.length > MaxLen) begin
        res[0]  = '{out_byte: 8'h00, last: 1'b1, status: STAT_LEN};
        st_next = '{crc: CRC_INIT, remaining: 16'd0, pkt_open: 1'b0};
      end else begin
        res[0] = '{out_byte: item.flags,        last: 1'b0, status: STAT_OK};
        res[1] = '{out_byte: item.seq,          last: 1'b0, status: STAT_OK};
        res[2] = '{out_byte: item.length[15:8], last: 1'b0, status: STAT_OK};
        res[3] = '{out_byte: item.length[7:0],  last: 1'b0, status: STAT_OK};
        if (item.length == 16'd0) begin
          res[4]  = '{out_byte: c4[15:8], last: 1'b0, status: STAT_OK};
          res[5]  = '{out_byte: c4[7:0],  last: 1'b1, status: STAT_OK};
          res_cnt = CNT_W'(6);
          st_next = '{crc: c4, remaining: 16'd0, pkt_open: 1'b0};
        end else begin
          res_cnt = CNT_W'(4);
          st_next = '{crc: c4, remaining: item.length, pkt_open: 1'b1};
        end
      end
    end else if (!st.pkt_open) begin
      res[0] = '{out_byte: 8'h00, last: 1'b1, status: STAT_NO_PKT};
    end else begin
      res[0] = '{out_byte: item.data_byte, last: 1'b0, status: STAT_OK};
      if (rem_dec == 16'd0) begin
        res[1]  = '{out_byte: cd[15:8], last: 1'b0, status: STAT_OK};
        res[2]  = '{out_byte: cd[7:0],  last: 1'b1, status: STAT_OK};
        res_cnt = CNT_W'(3);
        st_next = '{crc: cd, remaining: 16'd0, pkt_open: 1'b0};
      end else begin
        st_next = '{crc: cd, remaining: rem_dec, pkt_open: 1'b1};
      end
    end
  end

endmodule

`default_nettype wire
